// ----- src/lsfs_pkg.sv -----
`timescale 1ns / 1ps

package lsfs_pkg;

  // Sizes fixed by the item fields.
  localparam int MAX_LEDS_DEF = 256;
  localparam int DUTY_W       = 16;
  localparam int CNT_W        = 9;
  localparam int POS_W        = 13;
  localparam int RS_W         = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // The reset gap defaults to 300 us of 1250 ns PWM periods.
  localparam int RESET_TIME_US   = 300;
  localparam int PWM_PERIOD_NS   = 1250;
  localparam int RESET_SLOTS_DEF = RESET_TIME_US * 1000 / PWM_PERIOD_NS;

  // Command codes as they arrive on the request channel.
  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_FILL   = 3'd1;
  localparam logic [2:0] CMD_RENDER = 3'd2;
  localparam logic [2:0] CMD_ARM    = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 2'd3;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_FILL,
    OP_RENDER,
    OP_ARM,
    OP_TICK,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_BUSY,
    ST_RANGE
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_TICK_ADDR,
    BK_TICK_DATA
  } back_state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] first_led;
    logic [8:0] fill_count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [DUTY_W-1:0] duty_value;
    logic              slot_valid;
    logic              frame_last;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0]  led_count;
    logic [DUTY_W-1:0] one_duty;
    logic [DUTY_W-1:0] zero_duty;
    logic [RS_W-1:0]   reset_slots;
  } cfg_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    op_t        op;
    logic [7:0] first_led;
    logic [8:0] fill_count;
    logic [23:0] rgb;
  } job_t;

  // Divide by three for values below 1024, by reciprocal multiplication.
  function automatic logic [8:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = 20'(x) * 20'd683;
    return prod[19:11];
  endfunction

endpackage

// ----- src/led_strip_frame_serializer_core.sv -----
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// cmd       cmd_valid, cmd_stall   cmd (lsfs_pkg::cmd_t), one request
// rsp       rsp_valid, rsp_stall   rsp (lsfs_pkg::rsp_t), one result per request
// cfg       cfg_we                 cfg_index, cfg_data, write only
//
// A request is registered in a two-entry queue before dispatch.
// Write, arm, render, rejected requests and idle ticks are answered at dispatch.
// A streaming tick steps through position decode, frame store read and bit select.
// A bar fill makes one frame store write per cycle over its clipped range.
// Reset is synchronous; the frame store reads as zero at once through per-entry flags.
// A stalled result holds in the output register; the queue takes requests until full.

module led_strip_frame_serializer_core #(
  parameter int MAX_LEDS = lsfs_pkg::MAX_LEDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  lsfs_pkg::cmd_t                      cmd,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output lsfs_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [lsfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lsfs_pkg::cfg_t cfg;
  logic           job_valid;
  lsfs_pkg::job_t job;
  logic           job_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_count   <= 9'd1;
      cfg.one_duty    <= '0;
      cfg.zero_duty   <= '0;
      cfg.reset_slots <= lsfs_pkg::RS_W'(lsfs_pkg::RESET_SLOTS_DEF);
    end else if (cfg_we) begin
      case (cfg_index)
        lsfs_pkg::REG_LED_COUNT:   cfg.led_count   <= cfg_data[lsfs_pkg::CNT_W-1:0];
        lsfs_pkg::REG_ONE_DUTY:    cfg.one_duty    <= cfg_data[lsfs_pkg::DUTY_W-1:0];
        lsfs_pkg::REG_ZERO_DUTY:   cfg.zero_duty   <= cfg_data[lsfs_pkg::DUTY_W-1:0];
        lsfs_pkg::REG_RESET_SLOTS: cfg.reset_slots <= cfg_data[lsfs_pkg::RS_W-1:0];
        default: ;
      endcase
    end
  end

  lsfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  lsfs_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- src/lsfs_front.sv -----
`timescale 1ns / 1ps

module lsfs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  lsfs_pkg::cmd_t    cmd,
  output logic              job_valid,
  output lsfs_pkg::job_t    job,
  input  logic              job_pop
);

  lsfs_pkg::job_t job_in;
  lsfs_pkg::job_t slots [2];
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  logic           push;

  // Classify the request; a bar fill of zero LEDs is rejected outright.
  always_comb begin
    job_in.first_led  = cmd.first_led;
    job_in.fill_count = cmd.fill_count;
    job_in.rgb        = {cmd.red, cmd.green, cmd.blue};
    case (cmd.command)
      lsfs_pkg::CMD_WRITE:  job_in.op = lsfs_pkg::OP_WRITE;
      lsfs_pkg::CMD_FILL: begin
        if (cmd.fill_count == '0) job_in.op = lsfs_pkg::OP_BAD;
        else job_in.op = lsfs_pkg::OP_FILL;
      end
      lsfs_pkg::CMD_RENDER: job_in.op = lsfs_pkg::OP_RENDER;
      lsfs_pkg::CMD_ARM:    job_in.op = lsfs_pkg::OP_ARM;
      lsfs_pkg::CMD_TICK:   job_in.op = lsfs_pkg::OP_TICK;
      default:              job_in.op = lsfs_pkg::OP_BAD;
    endcase
  end

  // Two-entry queue toward the back end.
  assign cmd_stall = (count == 2'd2);
  assign push      = cmd_valid && !cmd_stall;
  assign job_valid = (count != 2'd0);
  assign job       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (job_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(job_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= job_in;
  end

endmodule

// ----- src/lsfs_back.sv -----
`timescale 1ns / 1ps

module lsfs_back #(
  parameter int MAX_LEDS = lsfs_pkg::MAX_LEDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lsfs_pkg::cfg_t    cfg,
  input  logic              job_valid,
  input  lsfs_pkg::job_t    job,
  output logic              job_pop,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output lsfs_pkg::rsp_t    rsp
);

  localparam int IW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  // Control state.
  lsfs_pkg::back_state_t         state, state_next;
  logic                          armed, armed_next;
  logic                          streaming, streaming_next;
  logic [lsfs_pkg::POS_W-1:0]    slot_pos, slot_pos_next;
  logic [lsfs_pkg::CNT_W-1:0]    frame_leds, frame_leds_next;
  logic                          rsp_valid_next;
  lsfs_pkg::rsp_t                rsp_next;

  // Work registers of a bar fill and a tick.
  logic [IW-1:0]                 fill_addr, fill_addr_next;
  logic [lsfs_pkg::CNT_W-1:0]    fill_left, fill_left_next;
  logic [23:0]                   fill_rgb, fill_rgb_next;
  logic                          tick_in_data, tick_in_data_next;
  logic                          tick_last, tick_last_next;
  logic [lsfs_pkg::POS_W-1:0]    tick_q, tick_q_next;
  logic [2:0]                    tick_bit, tick_bit_next;
  logic [1:0]                    tick_mod, tick_mod_next;
  logic [IW-1:0]                 tick_addr, tick_addr_next;

  // Frame store with one write port and one registered read port.
  logic [23:0]                   store [MAX_LEDS];
  logic [MAX_LEDS-1:0]           entry_valid;
  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr;
  logic [23:0]                   mem_wdata;
  logic                          mem_re;
  logic [IW-1:0]                 mem_raddr;
  logic [23:0]                   mem_q;
  logic                          valid_q;
  logic                          clr_en;
  logic [IW-1:0]                 clr_addr;

  // Combinational helpers.
  logic                          out_free;
  logic                          rsp_load;
  lsfs_pkg::rsp_t                rsp_value;
  logic [lsfs_pkg::CNT_W-1:0]    n;
  logic [lsfs_pkg::CNT_W-1:0]    first9;
  logic [lsfs_pkg::CNT_W-1:0]    start;
  logic [lsfs_pkg::CNT_W:0]      fill_end;
  logic [lsfs_pkg::CNT_W-1:0]    fill_cnt;
  logic [13:0]                   leds_bits;
  logic [14:0]                   data_end;
  logic [14:0]                   total;
  logic [13:0]                   pos_inc;
  logic                          in_data;
  logic                          last;
  logic [8:0]                    led;
  logic [9:0]                    led3;
  logic [23:0]                   entry;
  logic [7:0]                    byte_sel;

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      mem_q   <= store[mem_raddr];
      valid_q <= entry_valid[mem_raddr];
    end
  end

  // An entry never written since reset or since it was sent reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else begin
      if (mem_we) entry_valid[mem_waddr] <= 1'b1;
      if (clr_en) entry_valid[clr_addr] <= 1'b0;
    end
  end

  // Effective LED count and the bar fill range.
  always_comb begin
    if (cfg.led_count == '0) n = 9'd1;
    else if (int'(cfg.led_count) > MAX_LEDS) n = 9'(MAX_LEDS);
    else n = cfg.led_count;
    first9   = {1'b0, job.first_led};
    start    = (first9 >= n) ? first9 - n : first9;
    fill_end = {1'b0, start} + {1'b0, job.fill_count};
    fill_cnt = (fill_end > {1'b0, n}) ? n - start : job.fill_count;
  end

  // Slot position against the frame layout (24 bits per LED).
  always_comb begin
    leds_bits = {1'b0, frame_leds, 4'b0} + {2'b0, frame_leds, 3'b0};
    data_end  = 15'(cfg.reset_slots) + 15'(leds_bits);
    total     = data_end + 15'(cfg.reset_slots);
    pos_inc   = 14'(slot_pos) + 14'd1;
    in_data   = (slot_pos >= 13'(cfg.reset_slots)) && (15'(slot_pos) < data_end);
    last      = (15'(pos_inc) >= total);
  end

  // Split the data offset into LED index and bit within the LED.
  always_comb begin
    led  = lsfs_pkg::div3(tick_q[12:3]);
    led3 = {led, 1'b0} + {1'b0, led};
  end

  // Pick the byte of the entry in green, red, blue order.
  always_comb begin
    entry = valid_q ? mem_q : 24'd0;
    case (tick_mod)
      2'd0:    byte_sel = entry[15:8];
      2'd1:    byte_sel = entry[23:16];
      default: byte_sel = entry[7:0];
    endcase
  end

  assign out_free = !rsp_valid || !rsp_stall;

  // Sequencer: dispatch one request, then run its fill or tick steps.
  always_comb begin
    state_next        = state;
    armed_next        = armed;
    streaming_next    = streaming;
    slot_pos_next     = slot_pos;
    frame_leds_next   = frame_leds;
    fill_addr_next    = fill_addr;
    fill_left_next    = fill_left;
    fill_rgb_next     = fill_rgb;
    tick_in_data_next = tick_in_data;
    tick_last_next    = tick_last;
    tick_q_next       = tick_q;
    tick_bit_next     = tick_bit;
    tick_mod_next     = tick_mod;
    tick_addr_next    = tick_addr;
    job_pop           = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = fill_addr;
    mem_wdata         = fill_rgb;
    mem_re            = 1'b0;
    mem_raddr         = IW'(led);
    clr_en            = 1'b0;
    clr_addr          = tick_addr;
    rsp_load          = 1'b0;
    rsp_value         = '{status: lsfs_pkg::ST_OK, duty_value: '0,
                          slot_valid: 1'b0, frame_last: 1'b0};
    case (state)
      lsfs_pkg::BK_IDLE: begin
        if (job_valid && out_free) begin
          job_pop = 1'b1;
          case (job.op)
            lsfs_pkg::OP_WRITE: begin
              rsp_load = 1'b1;
              if (streaming) begin
                rsp_value.status = lsfs_pkg::ST_BUSY;
              end else if (first9 >= n) begin
                rsp_value.status = lsfs_pkg::ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IW'(job.first_led);
                mem_wdata = job.rgb;
              end
            end
            lsfs_pkg::OP_FILL: begin
              if (streaming) begin
                rsp_load         = 1'b1;
                rsp_value.status = lsfs_pkg::ST_BUSY;
              end else if (!armed) begin
                rsp_load         = 1'b1;
                rsp_value.status = lsfs_pkg::ST_INVALID;
              end else if (start >= n) begin
                rsp_load         = 1'b1;
                rsp_value.status = lsfs_pkg::ST_RANGE;
              end else begin
                // One-shot frame: disarm now, answer after the last write.
                armed_next      = 1'b0;
                streaming_next  = 1'b1;
                slot_pos_next   = '0;
                frame_leds_next = n;
                fill_addr_next  = IW'(start);
                fill_left_next  = fill_cnt;
                fill_rgb_next   = job.rgb;
                state_next      = lsfs_pkg::BK_FILL;
              end
            end
            lsfs_pkg::OP_RENDER: begin
              rsp_load = 1'b1;
              if (streaming) begin
                rsp_value.status = lsfs_pkg::ST_BUSY;
              end else if (!armed) begin
                rsp_value.status = lsfs_pkg::ST_INVALID;
              end else begin
                streaming_next  = 1'b1;
                slot_pos_next   = '0;
                frame_leds_next = n;
              end
            end
            lsfs_pkg::OP_ARM: begin
              rsp_load   = 1'b1;
              armed_next = 1'b1;
            end
            lsfs_pkg::OP_TICK: begin
              if (!streaming) begin
                rsp_load = 1'b1;
              end else begin
                tick_in_data_next = in_data;
                tick_last_next    = last;
                tick_q_next       = slot_pos - 13'(cfg.reset_slots);
                tick_bit_next     = tick_q_next[2:0];
                streaming_next    = !last;
                slot_pos_next     = last ? '0 : pos_inc[12:0];
                state_next        = lsfs_pkg::BK_TICK_ADDR;
              end
            end
            default: begin
              rsp_load         = 1'b1;
              rsp_value.status = lsfs_pkg::ST_INVALID;
            end
          endcase
        end
      end
      lsfs_pkg::BK_FILL: begin
        mem_we         = 1'b1;
        fill_addr_next = fill_addr + IW'(1);
        fill_left_next = fill_left - 9'd1;
        if (fill_left == 9'd1) begin
          rsp_load   = 1'b1;
          state_next = lsfs_pkg::BK_IDLE;
        end
      end
      lsfs_pkg::BK_TICK_ADDR: begin
        mem_re         = 1'b1;
        tick_addr_next = IW'(led);
        tick_mod_next  = 2'(tick_q[12:3] - led3);
        state_next     = lsfs_pkg::BK_TICK_DATA;
      end
      lsfs_pkg::BK_TICK_DATA: begin
        rsp_load             = 1'b1;
        rsp_value.slot_valid = 1'b1;
        rsp_value.frame_last = tick_last;
        if (tick_in_data) begin
          rsp_value.duty_value = byte_sel[3'd7 - tick_bit] ? cfg.one_duty : cfg.zero_duty;
          // The last bit of an LED empties its entry.
          if (tick_mod == 2'd2 && tick_bit == 3'd7) clr_en = 1'b1;
        end
        state_next = lsfs_pkg::BK_IDLE;
      end
      default: state_next = lsfs_pkg::BK_IDLE;
    endcase
    rsp_valid_next = rsp_load || (rsp_valid && rsp_stall);
    rsp_next       = rsp_load ? rsp_value : rsp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lsfs_pkg::BK_IDLE;
      armed      <= 1'b0;
      streaming  <= 1'b0;
      slot_pos   <= '0;
      frame_leds <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      armed      <= armed_next;
      streaming  <= streaming_next;
      slot_pos   <= slot_pos_next;
      frame_leds <= frame_leds_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp          <= rsp_next;
    fill_addr    <= fill_addr_next;
    fill_left    <= fill_left_next;
    fill_rgb     <= fill_rgb_next;
    tick_in_data <= tick_in_data_next;
    tick_last    <= tick_last_next;
    tick_q       <= tick_q_next;
    tick_bit     <= tick_bit_next;
    tick_mod     <= tick_mod_next;
    tick_addr    <= tick_addr_next;
  end

endmodule

// ----- src/lsfs_checker.sv -----
`timescale 1ns / 1ps

module lsfs_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input lsfs_pkg::rsp_t rsp
);

  // Requests taken but not yet answered.
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + 3'(cmd_valid && !cmd_stall) - 3'(rsp_valid && !rsp_stall);
    end
  end

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // No result without a request behind it.
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 3'd0)
    else $error("result without a pending request");

  // Queue, back end and output register hold at most three requests; the check allows four.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more requests taken than the block can hold");

  // Coming out of reset the block is empty and open.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !rsp_valid && !cmd_stall)
    else $error("block not empty after reset");

endmodule

bind led_strip_frame_serializer_core lsfs_checker u_lsfs_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- tb/sv/tb_led_strip_frame_serializer_core.sv -----
`timescale 1ns / 1ps

module tb_led_strip_frame_serializer_core;

  localparam int STRIP_MAX        = lsfs_pkg::MAX_LEDS_DEF;
  localparam int BITS_PER_PIXEL   = 24;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT      = 2000;
  localparam int RANDOM_BUDGET    = 190;

  // Command codes the block does not define; they must be refused.
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  typedef struct {
    lsfs_pkg::cmd_t    req;
    bit                fixed;
    lsfs_pkg::status_t st;
  } plan_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cmd_valid = 1'b0;
  logic                            cmd_stall;
  lsfs_pkg::cmd_t                  cmd       = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b1;
  lsfs_pkg::rsp_t                  rsp;
  logic                            cfg_we    = 1'b0;
  logic [lsfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lsfs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Expected slot stream: its own copy of the pixel store, flags and registers.
  logic [23:0]  pix_mem [STRIP_MAX];
  bit           armed;
  bit           sending;
  int unsigned  slot_pos;
  int unsigned  frame_len;
  logic [8:0]   reg_led_count;
  logic [15:0]  reg_one;
  logic [15:0]  reg_zero;
  logic [9:0]   reg_rst_slots;

  lsfs_pkg::rsp_t expected_slots [$];
  int unsigned  err_count;
  int unsigned  req_count;
  int unsigned  rsp_count;
  int unsigned  quiet_cycles;
  bit           tx_idle      = 1'b1;
  bit           rx_idle      = 1'b1;
  bit           rx_long_hold = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  led_strip_frame_serializer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Strip length in use: zero counts as one LED, anything past the store is clipped.
  function automatic int unsigned strip_len();
    int unsigned n;
    n = reg_led_count;
    if (n == 0) n = 1;
    if (n > STRIP_MAX) n = STRIP_MAX;
    return n;
  endfunction

  // Works out the response to one request and moves the expected state along.
  function automatic lsfs_pkg::rsp_t encode_command(input lsfs_pkg::cmd_t c);
    lsfs_pkg::rsp_t r;
    int unsigned n, start, span, i, p, data_end, total, q, led, b;
    logic [23:0] rgb, entry;
    logic [7:0]  lane;
    r = '0;
    n = strip_len();
    rgb = {c.red, c.green, c.blue};
    case (c.command)
      lsfs_pkg::CMD_WRITE: begin
        if (sending) r.status = lsfs_pkg::ST_BUSY;
        else if (c.first_led >= n) r.status = lsfs_pkg::ST_RANGE;
        else pix_mem[c.first_led] = rgb;
      end
      lsfs_pkg::CMD_FILL: begin
        start = c.first_led;
        span = c.fill_count;
        if (span == 0) r.status = lsfs_pkg::ST_INVALID;
        else if (sending) r.status = lsfs_pkg::ST_BUSY;
        else if (!armed) r.status = lsfs_pkg::ST_INVALID;
        else begin
          // A start past the strip wraps around once only.
          if (start >= n) start -= n;
          if (start >= n) begin
            r.status = lsfs_pkg::ST_RANGE;
          end else begin
            if (start + span > n) span = n - start;
            for (i = start; i < start + span; i++) pix_mem[i] = rgb;
            // A bar fill sends one frame and then disarms.
            frame_len = n;
            slot_pos = 0;
            sending = 1'b1;
            armed = 1'b0;
          end
        end
      end
      lsfs_pkg::CMD_RENDER: begin
        if (sending) r.status = lsfs_pkg::ST_BUSY;
        else if (!armed) r.status = lsfs_pkg::ST_INVALID;
        else begin
          frame_len = n;
          slot_pos = 0;
          sending = 1'b1;
        end
      end
      lsfs_pkg::CMD_ARM: armed = 1'b1;
      lsfs_pkg::CMD_TICK: begin
        if (sending) begin
          // The frame length is latched; the reset gap and duties are read live.
          p = slot_pos;
          data_end = reg_rst_slots + frame_len * BITS_PER_PIXEL;
          total = data_end + reg_rst_slots;
          if (p >= reg_rst_slots && p < data_end) begin
            q = p - reg_rst_slots;
            led = q / BITS_PER_PIXEL;
            b = q % BITS_PER_PIXEL;
            entry = (led < STRIP_MAX) ? pix_mem[led] : '0;
            // Green goes out first, then red, then blue, each MSB first.
            if (b < 8) lane = entry[15:8];
            else if (b < 16) lane = entry[23:16];
            else lane = entry[7:0];
            r.duty_value = lane[7 - (b % 8)] ? reg_one : reg_zero;
            if (b == BITS_PER_PIXEL - 1 && led < STRIP_MAX) pix_mem[led] = '0;
          end
          r.slot_valid = 1'b1;
          if (p + 1 >= total) begin
            r.frame_last = 1'b1;
            sending = 1'b0;
            slot_pos = 0;
          end else begin
            slot_pos = (p + 1) & 32'h1FFF;
          end
        end
      end
      default: r.status = lsfs_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic lsfs_pkg::cmd_t mk_req(input logic [2:0] op, input logic [7:0] first,
                                            input logic [8:0] span, input logic [23:0] rgb);
    lsfs_pkg::cmd_t c;
    c.command = op;
    c.first_led = first;
    c.fill_count = span;
    {c.red, c.green, c.blue} = rgb;
    return c;
  endfunction

  function automatic lsfs_pkg::cmd_t rand_req(input logic [2:0] op);
    return mk_req(op, 8'($urandom), 9'($urandom), 24'($urandom));
  endfunction

  function automatic plan_row_t plan_row(input logic [2:0] op, input logic [7:0] first,
                                         input logic [8:0] span, input logic [23:0] rgb,
                                         input bit fixed, input lsfs_pkg::status_t st);
    plan_row_t d;
    d.req = mk_req(op, first, span, rgb);
    d.fixed = fixed;
    d.st = st;
    return d;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    err_count++;
    $display("[%0t] result %0d: %s got %0h, expected %0h", $realtime, rsp_count, what,
             got, want);
  endtask

  // Offers one request after a random gap; the prediction is made once it is taken.
  task automatic send_req(input lsfs_pkg::cmd_t c, input bit fixed = 1'b0,
                          input lsfs_pkg::rsp_t want = '0);
    int unsigned    gap;
    lsfs_pkg::rsp_t r;
    if ($urandom_range(0, 63) == 0) tx_idle = !tx_idle;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    req_count++;
    r = encode_command(c);
    expected_slots.push_back(fixed ? want : r);
  endtask

  // Stops offering and waits for every outstanding result.
  task automatic drain();
    cmd_valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lsfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lsfs_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      lsfs_pkg::REG_LED_COUNT:   reg_led_count = val[8:0];
      lsfs_pkg::REG_ONE_DUTY:    reg_one = val;
      lsfs_pkg::REG_ZERO_DUTY:   reg_zero = val;
      lsfs_pkg::REG_RESET_SLOTS: reg_rst_slots = val[9:0];
      default: ;
    endcase
  endtask

  // Registers change only once the block has gone quiet.
  task automatic program_regs(input logic [8:0] leds, input logic [15:0] one_v,
                              input logic [15:0] zero_v, input logic [9:0] gap_slots);
    drain();
    write_reg(lsfs_pkg::REG_LED_COUNT, 16'(leds));
    write_reg(lsfs_pkg::REG_ONE_DUTY, one_v);
    write_reg(lsfs_pkg::REG_ZERO_DUTY, zero_v);
    write_reg(lsfs_pkg::REG_RESET_SLOTS, 16'(gap_slots));
    cfg_we <= 1'b0;
  endtask

  task automatic finish_frame();
    while (sending) send_req(rand_req(lsfs_pkg::CMD_TICK));
  endtask

  // Mostly whole frames (writes, arm, render or fill, ticks to the end) with
  // stray requests mixed in, plus fully random requests between frames.
  task automatic run_random(input int unsigned budget);
    int unsigned stop_at, n, k;
    stop_at = req_count + budget;
    while (req_count < stop_at) begin
      n = strip_len();
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, 4);
        repeat (k)
          send_req(mk_req(lsfs_pkg::CMD_WRITE, 8'($urandom_range(0, n + 1)), 9'($urandom),
                          24'($urandom)));
        if ($urandom_range(0, 3) != 0) send_req(rand_req(lsfs_pkg::CMD_ARM));
        if ($urandom_range(0, 1) == 0)
          send_req(rand_req(lsfs_pkg::CMD_RENDER));
        else
          send_req(mk_req(lsfs_pkg::CMD_FILL, 8'($urandom_range(0, 2 * n + 1)),
                          ($urandom_range(0, 3) == 0) ? 9'($urandom)
                                                      : 9'($urandom_range(1, n)),
                          24'($urandom)));
        while (sending) begin
          if ($urandom_range(0, 15) == 0) send_req(rand_req(3'($urandom)));
          else send_req(rand_req(lsfs_pkg::CMD_TICK));
        end
      end else begin
        send_req(rand_req(3'($urandom)));
      end
    end
  endtask

  // Result side: random stall before each result, one long hold on request.
  initial begin : result_sink
    int unsigned    wait_n;
    lsfs_pkg::rsp_t want;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
      wait_n = rx_idle ? $urandom_range(0, 12) : 0;
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        wait_n = LONG_HOLD_CYCLES;
      end
      if (wait_n != 0) begin
        rsp_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      rsp_count++;
      if (expected_slots.size() == 0) begin
        flag_mismatch("result with nothing expected, status", rsp.status, 0);
      end else begin
        want = expected_slots.pop_front();
        if (rsp.status !== want.status)
          flag_mismatch("status", rsp.status, want.status);
        if (rsp.duty_value !== want.duty_value)
          flag_mismatch("duty_value", rsp.duty_value, want.duty_value);
        if (rsp.slot_valid !== want.slot_valid)
          flag_mismatch("slot_valid", rsp.slot_valid, want.slot_valid);
        if (rsp.frame_last !== want.frame_last)
          flag_mismatch("frame_last", rsp.frame_last, want.frame_last);
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL led_strip_frame_serializer_core");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t      plan [$];
    lsfs_pkg::rsp_t want;

    foreach (pix_mem[i]) pix_mem[i] = '0;
    armed = 1'b0;
    sending = 1'b0;
    slot_pos = 0;
    frame_len = 0;
    reg_led_count = 9'd1;
    reg_one = '0;
    reg_zero = '0;
    reg_rst_slots = 10'(lsfs_pkg::RESET_SLOTS_DEF);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset values: one LED, both duties zero, 240 gap slots.
    plan.push_back(plan_row(lsfs_pkg::CMD_TICK, 8'd0, 9'd0, 24'h000000, 1'b1,
                            lsfs_pkg::ST_OK));
    plan.push_back(plan_row(lsfs_pkg::CMD_WRITE, 8'd0, 9'd0, 24'hA53CF0, 1'b1,
                            lsfs_pkg::ST_OK));
    plan.push_back(plan_row(lsfs_pkg::CMD_WRITE, 8'd1, 9'd0, 24'h123456, 1'b1,
                            lsfs_pkg::ST_RANGE));
    plan.push_back(plan_row(lsfs_pkg::CMD_WRITE, 8'd255, 9'd511, 24'hFFFFFF, 1'b1,
                            lsfs_pkg::ST_RANGE));
    plan.push_back(plan_row(lsfs_pkg::CMD_FILL, 8'd0, 9'd0, 24'hFFFFFF, 1'b1,
                            lsfs_pkg::ST_INVALID));
    plan.push_back(plan_row(lsfs_pkg::CMD_FILL, 8'd0, 9'd1, 24'h00FF00, 1'b1,
                            lsfs_pkg::ST_INVALID));
    plan.push_back(plan_row(lsfs_pkg::CMD_RENDER, 8'd0, 9'd0, 24'h000000, 1'b1,
                            lsfs_pkg::ST_INVALID));
    plan.push_back(plan_row(CMD_RSVD_5, 8'd0, 9'd0, 24'h000000, 1'b1,
                            lsfs_pkg::ST_INVALID));
    plan.push_back(plan_row(CMD_RSVD_6, 8'd255, 9'd256, 24'hFFFFFF, 1'b1,
                            lsfs_pkg::ST_INVALID));
    plan.push_back(plan_row(CMD_RSVD_7, 8'd0, 9'd1, 24'h000000, 1'b1,
                            lsfs_pkg::ST_INVALID));
    plan.push_back(plan_row(lsfs_pkg::CMD_ARM, 8'd0, 9'd0, 24'h000000, 1'b1,
                            lsfs_pkg::ST_OK));
    // Start still past the strip after one wrap.
    plan.push_back(plan_row(lsfs_pkg::CMD_FILL, 8'd2, 9'd5, 24'h0000FF, 1'b1,
                            lsfs_pkg::ST_RANGE));
    plan.push_back(plan_row(lsfs_pkg::CMD_FILL, 8'd255, 9'd256, 24'h0000FF, 1'b1,
                            lsfs_pkg::ST_RANGE));
    // Start wraps to zero and the count is clipped to the strip.
    plan.push_back(plan_row(lsfs_pkg::CMD_FILL, 8'd1, 9'd256, 24'hFF00FF, 1'b1,
                            lsfs_pkg::ST_OK));
    // While a frame is going out, only arm and tick are taken.
    plan.push_back(plan_row(lsfs_pkg::CMD_WRITE, 8'd0, 9'd0, 24'h111111, 1'b1,
                            lsfs_pkg::ST_BUSY));
    plan.push_back(plan_row(lsfs_pkg::CMD_FILL, 8'd0, 9'd0, 24'h222222, 1'b1,
                            lsfs_pkg::ST_INVALID));
    plan.push_back(plan_row(lsfs_pkg::CMD_FILL, 8'd0, 9'd1, 24'h333333, 1'b1,
                            lsfs_pkg::ST_BUSY));
    plan.push_back(plan_row(lsfs_pkg::CMD_RENDER, 8'd0, 9'd0, 24'h000000, 1'b1,
                            lsfs_pkg::ST_BUSY));
    plan.push_back(plan_row(lsfs_pkg::CMD_ARM, 8'd0, 9'd0, 24'h000000, 1'b1,
                            lsfs_pkg::ST_OK));
    plan.push_back(plan_row(lsfs_pkg::CMD_TICK, 8'd255, 9'd511, 24'hFFFFFF, 1'b0,
                            lsfs_pkg::ST_OK));
    plan.push_back(plan_row(lsfs_pkg::CMD_TICK, 8'd0, 9'd0, 24'h000000, 1'b0,
                            lsfs_pkg::ST_OK));
    foreach (plan[i]) begin
      want = '0;
      want.status = plan[i].st;
      send_req(plan[i].req, plan[i].fixed, want);
    end
    // Drop the gap mid-frame so the data bits follow at once.
    program_regs(9'd1, 16'hFFFF, 16'h0000, 10'd0);
    finish_frame();

    // Full strip: a count past the store clips to its size, so every index is in range.
    program_regs(9'd511, 16'hFFFF, 16'h0000, 10'd0);
    send_req(mk_req(lsfs_pkg::CMD_WRITE, 8'd255, 9'd0, 24'($urandom)));
    send_req(mk_req(lsfs_pkg::CMD_WRITE, 8'd0, 9'd0, 24'($urandom)));
    send_req(mk_req(lsfs_pkg::CMD_WRITE, 8'd100, 9'd0, 24'($urandom)));

    // Short strip: the count changes mid-frame, which must not alter the
    // latched frame length.
    program_regs(9'd3, 16'hFFFF, 16'h0000, 10'd2);
    send_req(rand_req(lsfs_pkg::CMD_ARM));
    send_req(mk_req(lsfs_pkg::CMD_FILL, 8'd4, 9'd256, 24'($urandom)));
    repeat (20) send_req(rand_req(lsfs_pkg::CMD_TICK));
    program_regs(9'd1, 16'h0000, 16'hFFFF, 10'd1);
    finish_frame();
    program_regs(9'd256, 16'h5A5A, 16'hA5A5, 10'd1);
    send_req(mk_req(lsfs_pkg::CMD_WRITE, 8'd255, 9'd0, 24'($urandom)));

    // Longest reset gap, then cut to zero so the position is already past the end.
    program_regs(9'd1, 16'h8001, 16'h7FFE, 10'd1023);
    send_req(rand_req(lsfs_pkg::CMD_ARM));
    send_req(rand_req(lsfs_pkg::CMD_RENDER));
    repeat (40) send_req(rand_req(lsfs_pkg::CMD_TICK));
    program_regs(9'd1, 16'h8001, 16'h7FFE, 10'd0);
    finish_frame();

    // Random part. The first phase opens with a long result hold while
    // requests keep coming back to back.
    program_regs(9'd2, 16'hFFFF, 16'h0000, 10'd1);
    rx_long_hold = 1'b1;
    tx_idle = 1'b0;
    run_random(RANDOM_BUDGET);
    program_regs(9'd0, 16'h0000, 16'hFFFF, 10'd0);
    run_random(RANDOM_BUDGET);
    program_regs(9'd4, 16'($urandom), 16'($urandom), 10'd3);
    run_random(RANDOM_BUDGET);
    program_regs(9'd3, 16'($urandom), 16'($urandom), 10'd2);
    run_random(RANDOM_BUDGET);
    drain();

    if (err_count == 0) begin
      $display("PASS led_strip_frame_serializer_core");
    end else begin
      $display("FAIL led_strip_frame_serializer_core");
    end
    $finish;
  end

endmodule
